// ----- design/gmr_pkg.sv -----
// ----------------------------------------------------------------------------
// gmr_pkg: shared types and constants for the grid maze reachability search
// Holds field widths, configuration register codes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gmr_pkg;

  // Width of a row or column count and of a stored coordinate
  localparam int DIM_W      = 7;
  // Width of a configured start or goal coordinate
  localparam int COORD_W    = 6;
  // Configuration write channel widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [DIM_W-1:0] GRID_DIM_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 3'd0,
    CFG_GRID_COLS = 3'd1,
    CFG_START_ROW = 3'd2,
    CFG_START_COL = 3'd3,
    CFG_GOAL_ROW  = 3'd4,
    CFG_GOAL_COL  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0]   grid_rows;
    logic [DIM_W-1:0]   grid_cols;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] goal_row;
    logic [COORD_W-1:0] goal_col;
  } cfg_t;

  // One stack entry: a cell by row and column
  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } pos_t;

  // Neighbor visiting order
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_LOAD    = 3'd0,
    ST_CLEAR   = 3'd1,
    ST_INIT    = 3'd2,
    ST_POP     = 3'd3,
    ST_POP_CHK = 3'd4,
    ST_NB_RD   = 3'd5,
    ST_NB_CHK  = 3'd6,
    ST_FINISH  = 3'd7
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // store one incoming cell
    logic clear;   // clear one visited entry
    logic init;    // check start and goal, push the start cell
    logic pop;     // read the stack top
    logic take;    // latch popped cell, compare with goal
    logic nb_rd;   // read wall and visited of one neighbor
    logic nb_chk;  // mark and push the neighbor if open
    logic emit;    // hand the answer to the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic pos_bad;
    logic stack_empty;
    logic hit;
    logic last_dir;
    logic found;
  } dp_stat_t;

endpackage

// ----- design/gmr_if.sv -----
// ----------------------------------------------------------------------------
// gmr_if: handshake channels of the grid maze reachability search
// Cell input channel, result output channel and configuration write channel,
// each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface gmr_cell_if;
  logic valid;
  logic ready;
  logic is_wall;
  logic last_cell;

  modport source (output valid, output is_wall, output last_cell, input ready);
  modport sink   (input valid, input is_wall, input last_cell, output ready);
endinterface

interface gmr_result_if;
  logic valid;
  logic ready;
  logic route_found;

  modport source (output valid, output route_found, input ready);
  modport sink   (input valid, input route_found, output ready);
endinterface

interface gmr_cfg_if;
  import gmr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- design/grid_maze_reachability_search_unit.sv -----
// ----------------------------------------------------------------------------
// grid_maze_reachability_search_unit: depth-first maze reachability search
// Loads a maze one cell per cycle, then searches from the start cell and
// reports whether the goal cell is reachable.
// ----------------------------------------------------------------------------
// After the last cell: clear the visited entries of rows*cols not loaded, check
// start and goal and push the start cell, then per popped cell pop, take, read and
// check four neighbors (stop when the goal is hit), until the stack runs empty; finish.
// Throughput: one cell per cycle while loading, also while a result waits; cells
// are refused during a search, paced by the single-ported maps and stack.
// Reset loads default configuration and an empty load position; no clearing pass.
module grid_maze_reachability_search_unit #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gmr_cell_if.sink             cell_i,
  gmr_result_if.source         result_o,
  gmr_cfg_if.sink              cfg_i
);
  import gmr_pkg::*;

  cfg_t     cfg_q;
  logic     res_valid_q;
  logic     res_found_q;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_rows <= GRID_DIM_RESET;
      cfg_q.grid_cols <= GRID_DIM_RESET;
      cfg_q.start_row <= '0;
      cfg_q.start_col <= '0;
      cfg_q.goal_row  <= '0;
      cfg_q.goal_col  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.addr))
        CFG_GRID_ROWS: cfg_q.grid_rows <= cfg_i.data;
        CFG_GRID_COLS: cfg_q.grid_cols <= cfg_i.data;
        CFG_START_ROW: cfg_q.start_row <= cfg_i.data[COORD_W-1:0];
        CFG_START_COL: cfg_q.start_col <= cfg_i.data[COORD_W-1:0];
        CFG_GOAL_ROW:  cfg_q.goal_row  <= cfg_i.data[COORD_W-1:0];
        CFG_GOAL_COL:  cfg_q.goal_col  <= cfg_i.data[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gmr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (cell_i.valid),
    .cell_last_i  (cell_i.last_cell),
    .out_free_i   (!res_valid_q),
    .stat_i       (stat),
    .cell_ready_o (cell_i.ready),
    .cmd_o        (cmd)
  );

  gmr_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .is_wall_i   (cell_i.is_wall),
    .last_cell_i (cell_i.last_cell),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  // Result register: load on emit, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      res_found_q <= stat.found;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.route_found = res_found_q;

endmodule

// ----- design/gmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// gmr_ctrl: search sequencer
// Accepts cells while loading, then steps the datapath through clearing,
// start push, pop and the four neighbor checks of every popped cell.
// ----------------------------------------------------------------------------
module gmr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cell_valid_i,
  input  logic             cell_last_i,
  input  logic             out_free_i,
  input  gmr_pkg::dp_stat_t stat_i,
  output logic             cell_ready_o,
  output gmr_pkg::dp_cmd_t cmd_o
);
  import gmr_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cell_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        cell_ready_o = 1'b1;
        if (cell_valid_i) begin
          cmd_o.load = 1'b1;
          if (cell_last_i) begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        if (stat_i.clr_done) begin
          state_d = ST_INIT;
        end else begin
          cmd_o.clear = 1'b1;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = stat_i.pos_bad ? ST_FINISH : ST_POP;
      end
      ST_POP: begin
        if (stat_i.stack_empty) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_POP_CHK;
        end
      end
      ST_POP_CHK: begin
        cmd_o.take = 1'b1;
        state_d    = stat_i.hit ? ST_FINISH : ST_NB_RD;
      end
      ST_NB_RD: begin
        cmd_o.nb_rd = 1'b1;
        state_d     = ST_NB_CHK;
      end
      ST_NB_CHK: begin
        cmd_o.nb_chk = 1'b1;
        state_d      = stat_i.last_dir ? ST_POP : ST_NB_RD;
      end
      ST_FINISH: begin
        // Wait for the result register to drain
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// ----- design/gmr_dpath.sv -----
// ----------------------------------------------------------------------------
// gmr_dpath: maze storage and search datapath
// Holds the wall map, visited map and cell stack memories, the load and
// clear pointers, the stack pointer and the neighbor address logic.
// ----------------------------------------------------------------------------
module gmr_dpath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gmr_pkg::cfg_t     cfg_i,
  input  logic              is_wall_i,
  input  logic              last_cell_i,
  input  gmr_pkg::dp_cmd_t  cmd_i,
  output gmr_pkg::dp_stat_t stat_o
);
  import gmr_pkg::*;

  localparam int CellCap = MAX_ROWS * MAX_COLS;
  localparam int AW      = $clog2(CellCap);
  localparam int CW      = $clog2(CellCap + 1);
  localparam int PW      = 2 * DIM_W;

  // Memories
  logic wall_mem  [CellCap];
  logic vis_mem   [CellCap];
  pos_t stack_mem [CellCap];

  logic          wall_rd_q;
  logic          vis_rd_q;
  pos_t          stk_rd_q;

  logic [CW-1:0] load_pos_q;
  logic [CW-1:0] clr_ptr_q;
  logic [CW-1:0] sp_q;
  dir_e          dir_q;
  logic          found_q;
  pos_t          cur_q;
  pos_t          nb_pos_q;
  logic          nb_ok_q;
  logic [AW-1:0] nb_addr_q;

  logic [DIM_W-1:0] rows_c;
  logic [DIM_W-1:0] cols_c;
  logic [PW-1:0]    total_cells;
  logic             can_store;
  logic [CW-1:0]    n_loaded;
  logic [CW-1:0]    sp_dec;
  logic             pos_bad;
  logic             hit;
  pos_t             start_pos;
  logic [PW:0]      start_lin;
  logic [AW-1:0]    start_addr;
  pos_t             nb_pos;
  logic             nb_ok;
  logic [PW:0]      nb_lin;
  logic [AW-1:0]    nb_addr;
  logic             push_ok;
  logic             stk_room;

  logic             vis_we;
  logic [AW-1:0]    vis_waddr;
  logic             vis_wdata;
  logic             stk_we;
  logic [AW-1:0]    stk_waddr;
  pos_t             stk_wdata;

  // Clamp the grid size to between 1 and the storage
  always_comb begin
    rows_c = cfg_i.grid_rows;
    if (cfg_i.grid_rows == '0) begin
      rows_c = DIM_W'(1);
    end else if (int'(cfg_i.grid_rows) > MAX_ROWS) begin
      rows_c = DIM_W'(MAX_ROWS);
    end
    cols_c = cfg_i.grid_cols;
    if (cfg_i.grid_cols == '0) begin
      cols_c = DIM_W'(1);
    end else if (int'(cfg_i.grid_cols) > MAX_COLS) begin
      cols_c = DIM_W'(MAX_COLS);
    end
  end

  assign total_cells = PW'(rows_c) * PW'(cols_c);

  // Load and stack bookkeeping
  assign can_store = load_pos_q < CW'(CellCap);
  assign n_loaded  = can_store ? load_pos_q + CW'(1) : load_pos_q;
  assign sp_dec    = sp_q - CW'(1);
  assign stk_room  = sp_q < CW'(CellCap);

  // Start and goal range check
  assign pos_bad = ({1'b0, cfg_i.start_row} >= rows_c) || ({1'b0, cfg_i.start_col} >= cols_c) ||
                   ({1'b0, cfg_i.goal_row} >= rows_c)  || ({1'b0, cfg_i.goal_col} >= cols_c);

  assign start_pos.row = {1'b0, cfg_i.start_row};
  assign start_pos.col = {1'b0, cfg_i.start_col};
  assign start_lin     = (PW+1)'(PW'(start_pos.row) * PW'(cols_c)) + (PW+1)'(start_pos.col);
  assign start_addr    = AW'(start_lin);

  assign hit = (stk_rd_q.row == {1'b0, cfg_i.goal_row}) &&
               (stk_rd_q.col == {1'b0, cfg_i.goal_col});

  // Neighbor of the current cell in the present direction
  always_comb begin
    nb_pos = cur_q;
    nb_ok  = 1'b0;
    case (dir_q)
      DIR_UP: begin
        nb_ok      = cur_q.row != '0;
        nb_pos.row = cur_q.row - DIM_W'(1);
      end
      DIR_DOWN: begin
        nb_ok      = ({1'b0, cur_q.row} + (DIM_W+1)'(1)) < {1'b0, rows_c};
        nb_pos.row = cur_q.row + DIM_W'(1);
      end
      DIR_LEFT: begin
        nb_ok      = cur_q.col != '0;
        nb_pos.col = cur_q.col - DIM_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok      = ({1'b0, cur_q.col} + (DIM_W+1)'(1)) < {1'b0, cols_c};
        nb_pos.col = cur_q.col + DIM_W'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_lin  = (PW+1)'(PW'(nb_pos.row) * PW'(cols_c)) + (PW+1)'(nb_pos.col);
  assign nb_addr = AW'(nb_lin);
  assign push_ok = nb_ok_q && !wall_rd_q && !vis_rd_q;

  // Visited map write port
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = '0;
    vis_wdata = 1'b0;
    if (cmd_i.load && can_store) begin
      vis_we    = 1'b1;
      vis_waddr = load_pos_q[AW-1:0];
    end else if (cmd_i.clear) begin
      vis_we    = 1'b1;
      vis_waddr = clr_ptr_q[AW-1:0];
    end else if (cmd_i.init && !pos_bad) begin
      vis_we    = 1'b1;
      vis_waddr = start_addr;
      vis_wdata = 1'b1;
    end else if (cmd_i.nb_chk && push_ok) begin
      vis_we    = 1'b1;
      vis_waddr = nb_addr_q;
      vis_wdata = 1'b1;
    end
  end

  // Stack write port
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = start_pos;
    if (cmd_i.init && !pos_bad) begin
      stk_we = 1'b1;
    end else if (cmd_i.nb_chk && push_ok && stk_room) begin
      stk_we    = 1'b1;
      stk_waddr = sp_q[AW-1:0];
      stk_wdata = nb_pos_q;
    end
  end

  // Wall map: write on load, read per neighbor
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && can_store) begin
      wall_mem[load_pos_q[AW-1:0]] <= is_wall_i;
    end
    if (cmd_i.nb_rd) begin
      wall_rd_q <= wall_mem[nb_addr];
    end
  end

  // Visited map
  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (cmd_i.nb_rd) begin
      vis_rd_q <= vis_mem[nb_addr];
    end
  end

  // Cell stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (cmd_i.pop) begin
      stk_rd_q <= stack_mem[sp_dec[AW-1:0]];
    end
  end

  // Pointers and search flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      clr_ptr_q  <= '0;
      sp_q       <= '0;
      dir_q      <= DIR_UP;
      found_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (last_cell_i) begin
          load_pos_q <= '0;
          clr_ptr_q  <= n_loaded;
        end else begin
          load_pos_q <= n_loaded;
        end
      end
      if (cmd_i.clear) begin
        clr_ptr_q <= clr_ptr_q + CW'(1);
      end
      if (cmd_i.init) begin
        found_q <= 1'b0;
        sp_q    <= pos_bad ? '0 : CW'(1);
      end
      if (cmd_i.pop) begin
        sp_q <= sp_dec;
      end
      if (cmd_i.take) begin
        found_q <= hit;
        dir_q   <= DIR_UP;
      end
      if (cmd_i.nb_chk) begin
        if (push_ok && stk_room) begin
          sp_q <= sp_q + CW'(1);
        end
        dir_q <= dir_e'(2'(dir_q + 2'd1));
      end
    end
  end

  // Current cell and neighbor capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cur_q <= stk_rd_q;
    end
    if (cmd_i.nb_rd) begin
      nb_pos_q  <= nb_pos;
      nb_ok_q   <= nb_ok;
      nb_addr_q <= nb_addr;
    end
  end

  // Status to the controller
  assign stat_o.clr_done    = 32'(clr_ptr_q) >= 32'(total_cells);
  assign stat_o.pos_bad     = pos_bad;
  assign stat_o.stack_empty = sp_q == '0;
  assign stat_o.hit         = hit;
  assign stat_o.last_dir    = dir_q == DIR_RIGHT;
  assign stat_o.found       = found_q;

endmodule
